/* design/pulse_saw_noise_oscillator_macros.svh */
// assertion macros for the oscillator checker
`ifndef PULSE_SAW_NOISE_OSCILLATOR_MACROS_SVH
`define PULSE_SAW_NOISE_OSCILLATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PSNO_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psno check failed");

// antecedent implies consequent in the next cycle
`define PSNO_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psno check failed");

`endif

/* design/psno_pkg.sv */
// shared types, constants and helpers for the pulse/saw/noise oscillator
package psno_pkg;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SQUARE = 2'd1,
        MODE_SAW    = 2'd2,
        MODE_NOISE  = 2'd3
    } t_mode;

    localparam int F_W    = 48;  // pitch * fine_tune after the octave shift
    localparam int NUM_W  = 54;  // sample_rate << 28 after the octave shift
    localparam int WF_W   = 21;  // width fraction, signed q16
    localparam int HL_W   = 18;  // hold length, signed q12
    localparam int SR_W   = 18;
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 56;

    localparam logic [2:0] REG_WAVEFORM     = 3'd0;
    localparam logic [2:0] REG_OCTAVE_SHIFT = 3'd1;
    localparam logic [2:0] REG_FINE_TUNE    = 3'd2;
    localparam logic [2:0] REG_BASE_WIDTH   = 3'd3;
    localparam logic [2:0] REG_HOLD_SECONDS = 3'd4;
    localparam logic [2:0] REG_MOD_DEPTH    = 3'd5;
    localparam logic [2:0] REG_SAMPLE_RATE  = 3'd6;

    localparam logic [23:0] DEFAULT_PITCH = 24'd28160;  // 110 hz in 1/256 hz
    localparam logic [31:0] LFSR_TOGGLE   = 32'h8020_0003;
    localparam logic [15:0] NOISE_MOD     = 16'd32767;

    typedef struct packed {
        t_mode              mode;
        logic signed [4:0]  oct;
        logic [15:0]        fine;
        logic [15:0]        base;
        logic [15:0]        hold;
        logic signed [15:0] depth;
        logic [SR_W-1:0]    sr;
    } t_cfg;

    typedef struct packed {
        t_mode                   mode;
        logic [F_W-1:0]          f;
        logic [NUM_W-1:0]        num;
        logic signed [WF_W-1:0]  wf;
        logic signed [HL_W-1:0]  hl;
    } t_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV_CYC,
        B_MUL_LO,
        B_MUL_HI,
        B_PHASE,
        B_DIV_SAW,
        B_NZ_LEN,
        B_NZ_STEP,
        B_NZ_HOLD,
        B_OUT
    } t_bstate;

    function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
        logic signed [15:0] r;
        if (v > 66'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -66'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* design/psno_front.sv */
// front end: takes a tick, classifies the mode and forms the state-free products
module psno_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psno_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_pitch_present,
    input  logic [23:0]         i_pitch_hz,
    input  logic signed [15:0]  i_width_mod,
    input  logic signed [15:0]  i_hold_mod,
    output logic                o_item_valid,
    output psno_pkg::t_item     o_item,
    input  logic                i_item_ready
);
    import psno_pkg::*;

    logic               r_v;
    t_item              r_item;
    t_item              n_item;
    logic signed [4:0]  oct_c;
    logic [3:0]         up_sh;
    logic [3:0]         dn_sh;
    logic [23:0]        pitch;
    logic [39:0]        f_raw;
    logic signed [31:0] wprod;
    logic signed [31:0] hprod;
    logic               accept;

    always_comb begin
        if (i_cfg.oct > 5'sd8) begin
            oct_c = 5'sd8;
        end else if (i_cfg.oct < -5'sd8) begin
            oct_c = -5'sd8;
        end else begin
            oct_c = i_cfg.oct;
        end
    end

    assign up_sh = (oct_c > 5'sd0) ? oct_c[3:0] : 4'd0;
    assign dn_sh = (oct_c < 5'sd0) ? 4'((-oct_c)) : 4'd0;
    assign pitch = i_pitch_present ? i_pitch_hz : DEFAULT_PITCH;
    assign f_raw = 40'(pitch) * 40'(i_cfg.fine);
    assign wprod = $signed({{16{i_width_mod[15]}}, i_width_mod})
                 * $signed({{16{i_cfg.depth[15]}}, i_cfg.depth});
    assign hprod = $signed({{16{i_hold_mod[15]}}, i_hold_mod})
                 * $signed({{16{i_cfg.depth[15]}}, i_cfg.depth});

    always_comb begin
        n_item.mode = i_cfg.mode;
        n_item.f    = F_W'(f_raw) << up_sh;
        n_item.num  = (NUM_W'(i_cfg.sr) << 28) << dn_sh;
        // arithmetic shift of the product is the floor division
        n_item.wf   = $signed({5'b0, i_cfg.base}) + $signed(wprod[31:11]);
        n_item.hl   = $signed({2'b0, i_cfg.hold}) + $signed({hprod[31], hprod[31:15]});
    end

    assign o_in_ready   = !r_v || i_item_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_item_valid = r_v;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_item_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* design/psno_fifo.sv */
// small register queue between the front and back ends
module psno_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* design/psno_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module psno_div #(
    parameter int NW = 64,
    parameter int DW = 56
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          ge;

    assign rem_sh = {r_rem, r_quot[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, r_den};
    assign ge     = !diff[DW+1];
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out of the top as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NW-2:0], ge};
            r_rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

endmodule

/* design/psno_back.sv */
// back end: cycle length, pulse width, phase, waveform and noise hold
module psno_back #(
    parameter int PHASE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psno_pkg::t_cfg     i_cfg,
    input  logic               i_item_valid,
    input  psno_pkg::t_item    i_item,
    output logic               o_item_pop,
    output logic               o_out_valid,
    output logic signed [15:0] o_sample_out,
    input  logic               i_out_ready
);
    import psno_pkg::*;

    localparam int CW    = PHASE_BITS + 8;
    localparam int HW    = (CW + 1) / 2;
    localparam int ACC_W = WF_W + CW + 1;
    localparam int PW_W  = ACC_W - 24;
    localparam int E_W   = PW_W + 10;
    localparam int LP_W  = HL_W + SR_W + 1;
    localparam int LEN_W = LP_W - 12;
    localparam logic [CW-1:0] CYC_MAX = {{PHASE_BITS{1'b1}}, 8'b0};

    t_bstate                 r_state;
    t_bstate                 n_state;
    t_item                   r_item;
    logic [CW-1:0]           r_cyc;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PW_W-1:0]  r_pw;
    logic [PHASE_BITS-1:0]   r_ph;
    logic signed [LEN_W-1:0] r_len;
    logic [31:0]             r_lfsr;
    logic signed [15:0]      r_held;
    logic                    r_hit;
    logic                    r_rise;
    logic                    r_dneg;
    logic signed [15:0]      r_res;
    logic                    r_out_v;
    logic signed [15:0]      r_out;

    logic                    pop;
    logic                    div_start;
    logic [DIV_NW-1:0]       div_num;
    logic [DIV_DW-1:0]       div_den;
    logic                    div_done;
    logic [DIV_NW-1:0]       div_quot;
    logic                    out_load;

    logic signed [ACC_W-1:0] lo_prod;
    logic signed [ACC_W-1:0] hi_prod;
    logic signed [ACC_W-1:0] acc_f;
    logic signed [ACC_W-1:0] acc_adj;
    logic [PHASE_BITS-1:0]   ph_inc;
    logic                    ph_wrap;
    logic [PHASE_BITS-1:0]   pos;
    logic                    rise;
    logic signed [E_W-1:0]   n_val;
    logic signed [E_W-1:0]   d_val;
    logic signed [E_W-1:0]   d_abs;
    logic signed [LP_W-1:0]  lprod;
    logic signed [LP_W-1:0]  lprod_adj;
    logic                    nz_hit;
    logic [31:0]             lfsr_nx;
    logic [16:0]             fold1;
    logic [15:0]             fold2;
    logic [14:0]             lfsr_mod;
    logic [16:0]             held_wide;
    logic signed [15:0]      held_now;
    logic signed [65:0]      saw_wide;

    psno_div #(
        .NW(DIV_NW),
        .DW(DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // pulse width product, low then high half of the cycle length
    assign lo_prod = $signed(r_item.wf) * $signed({1'b0, r_cyc[HW-1:0]});
    assign hi_prod = $signed(r_item.wf) * $signed({1'b0, r_cyc[CW-1:HW]});
    assign acc_f   = r_acc + (hi_prod <<< HW);
    assign acc_adj = acc_f + (acc_f[ACC_W-1] ? ACC_W'(24'hFF_FFFF) : '0);

    assign ph_inc  = r_ph + 1'b1;
    assign ph_wrap = ({ph_inc, 8'b0} > r_cyc);
    assign pos     = ph_wrap ? '0 : ph_inc;
    assign rise    = ($signed({1'b0, pos}) < r_pw);
    assign n_val   = E_W'($signed({1'b0, pos}) - r_pw) <<< 8;
    assign d_val   = $signed({1'b0, r_cyc}) - (E_W'(r_pw) <<< 8);
    assign d_abs   = d_val[E_W-1] ? -d_val : d_val;

    assign lprod     = $signed(r_item.hl) * $signed({1'b0, i_cfg.sr});
    assign lprod_adj = lprod + (lprod[LP_W-1] ? LP_W'(12'hFFF) : '0);

    assign nz_hit  = ($signed({1'b0, ph_inc}) > r_len);
    assign lfsr_nx = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TOGGLE : 32'h0);

    // mod 2^15-1 by folding 15-bit chunks
    assign fold1     = 17'(r_lfsr[14:0]) + 17'(r_lfsr[29:15]) + 17'(r_lfsr[31:30]);
    assign fold2     = 16'(fold1[14:0]) + 16'(fold1[16:15]);
    assign lfsr_mod  = (fold2 >= NOISE_MOD) ? 15'(fold2 - NOISE_MOD) : fold2[14:0];
    assign held_wide = {1'b0, lfsr_mod, 1'b0} - 17'(NOISE_MOD);
    assign held_now  = r_hit ? $signed(held_wide[15:0]) : r_held;

    always_comb begin
        if (r_rise) begin
            saw_wide = $signed({2'b0, div_quot}) - 66'sd32768;
        end else if (r_dneg) begin
            saw_wide = 66'sd32768 + $signed({2'b0, div_quot});
        end else begin
            saw_wide = 66'sd32768 - $signed({2'b0, div_quot});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.mode)
                        MODE_NONE:  n_state = B_OUT;
                        MODE_NOISE: n_state = B_NZ_LEN;
                        default:    n_state = B_DIV_CYC;
                    endcase
                end
            end
            B_DIV_CYC: begin
                if (div_done) begin
                    n_state = B_MUL_LO;
                end
            end
            B_MUL_LO:  n_state = B_MUL_HI;
            B_MUL_HI:  n_state = B_PHASE;
            B_PHASE: begin
                if (r_item.mode == MODE_SQUARE || (!rise && d_val == '0)) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_DIV_SAW;
                end
            end
            B_DIV_SAW: begin
                if (div_done) begin
                    n_state = B_OUT;
                end
            end
            B_NZ_LEN:  n_state = B_NZ_STEP;
            B_NZ_STEP: n_state = B_NZ_HOLD;
            B_NZ_HOLD: n_state = B_OUT;
            B_OUT: begin
                if (!r_out_v || i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default:   n_state = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_num   = {{(DIV_NW-NUM_W){1'b0}}, i_item.num};
        div_den   = {{(DIV_DW-F_W){1'b0}}, i_item.f};
        out_load  = 1'b0;
        case (r_state)
            B_IDLE: begin
                pop       = i_item_valid;
                div_start = i_item_valid && (i_item.mode inside {MODE_SQUARE, MODE_SAW});
            end
            B_PHASE: begin
                if (rise) begin
                    div_num = DIV_NW'({pos, 16'b0});
                    div_den = DIV_DW'($unsigned(r_pw));
                end else begin
                    div_num = DIV_NW'({n_val[E_W-2:0], 16'b0});
                    div_den = DIV_DW'($unsigned(d_abs));
                end
                div_start = (r_item.mode == MODE_SAW) && (rise || d_val != '0);
            end
            B_OUT: begin
                out_load = !r_out_v || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign o_item_pop   = pop;
    assign o_out_valid  = r_out_v;
    assign o_sample_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_out_v <= 1'b0;
            r_ph    <= '0;
            r_held  <= '0;
            r_lfsr  <= 32'd1;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_state == B_PHASE) begin
                r_ph <= pos;
            end
            if (r_state == B_NZ_STEP) begin
                r_ph <= nz_hit ? '0 : ph_inc;
                if (nz_hit) begin
                    r_lfsr <= lfsr_nx;
                end
            end
            if (r_state == B_NZ_HOLD) begin
                r_held <= held_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        case (r_state)
            B_IDLE: begin
                if (pop) begin
                    r_item <= i_item;
                    r_res  <= '0;
                end
            end
            B_DIV_CYC: begin
                if (div_done) begin
                    r_cyc <= (div_quot > DIV_NW'(CYC_MAX)) ? CYC_MAX : div_quot[CW-1:0];
                end
            end
            B_MUL_LO: begin
                r_acc <= lo_prod;
            end
            B_MUL_HI: begin
                r_pw <= acc_adj[ACC_W-1:24];
            end
            B_PHASE: begin
                r_rise <= rise;
                r_dneg <= d_val[E_W-1];
                if (r_item.mode == MODE_SQUARE) begin
                    r_res <= rise ? 16'sh7FFF : 16'sh8000;
                end else begin
                    r_res <= 16'sh8000;  // empty falling ramp
                end
            end
            B_DIV_SAW: begin
                if (div_done) begin
                    r_res <= sat16(saw_wide);
                end
            end
            B_NZ_LEN: begin
                r_len <= lprod_adj[LP_W-1:12];
            end
            B_NZ_STEP: begin
                r_hit <= nz_hit;
            end
            B_NZ_HOLD: begin
                // only -32767 scales past the q1.15 grid
                r_res <= (held_now == -16'sd32767) ? 16'sh8000 : held_now;
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/pulse_saw_noise_oscillator.sv */
// top level: config registers, front end, queue and back end of the oscillator
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_ready        pitch_present, pitch_hz, width_mod,
//                                                      hold_mod
//  out       output     o_out_valid / i_out_ready      sample_out
//  config    input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// a tick in square mode passes once through the 64-step radix-2 divider in the back
// end, in saw mode up to twice, and in noise and none mode not at all.
// reset is synchronous and active low; it loads the register defaults, clears the
// phase and the held noise and seeds the lfsr with one.
// the front end and a two-entry queue keep taking ticks while the back end works or
// while a finished sample waits on a stalled output.
module pulse_saw_noise_oscillator #(
    parameter int PHASE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_pitch_present,
    input  logic [23:0]        i_pitch_hz,
    input  logic signed [15:0] i_width_mod,
    input  logic signed [15:0] i_hold_mod,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import psno_pkg::*;

    t_mode              r_waveform;
    logic signed [4:0]  r_octave_shift;
    logic [15:0]        r_fine_tune;
    logic [15:0]        r_base_width;
    logic [15:0]        r_hold_seconds;
    logic signed [15:0] r_mod_depth;
    logic [SR_W-1:0]    r_sample_rate;

    t_cfg               cfg;
    logic               cfg_wr;
    logic [2:0]         reg_idx;
    logic               fr_valid;
    t_item              fr_item;
    logic               q_ready;
    logic               q_valid;
    logic [$bits(t_item)-1:0] q_data;
    t_item              q_item;
    logic               q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform     <= MODE_SQUARE;
            r_octave_shift <= 5'sd0;
            r_fine_tune    <= 16'd4096;
            r_base_width   <= 16'd32768;
            r_hold_seconds <= 16'd410;
            r_mod_depth    <= 16'sd4096;
            r_sample_rate  <= SR_W'(48000);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WAVEFORM:     r_waveform     <= t_mode'(pwdata[1:0]);
                REG_OCTAVE_SHIFT: r_octave_shift <= $signed(pwdata[4:0]);
                REG_FINE_TUNE:    r_fine_tune    <= pwdata[15:0];
                REG_BASE_WIDTH:   r_base_width   <= pwdata[15:0];
                REG_HOLD_SECONDS: r_hold_seconds <= pwdata[15:0];
                REG_MOD_DEPTH:    r_mod_depth    <= $signed(pwdata[15:0]);
                REG_SAMPLE_RATE:  r_sample_rate  <= pwdata[SR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WAVEFORM:     prdata = 32'(r_waveform);
            REG_OCTAVE_SHIFT: prdata = 32'($unsigned(r_octave_shift));
            REG_FINE_TUNE:    prdata = 32'(r_fine_tune);
            REG_BASE_WIDTH:   prdata = 32'(r_base_width);
            REG_HOLD_SECONDS: prdata = 32'(r_hold_seconds);
            REG_MOD_DEPTH:    prdata = 32'($unsigned(r_mod_depth));
            REG_SAMPLE_RATE:  prdata = 32'(r_sample_rate);
            default:          prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.mode  = r_waveform;
        cfg.oct   = r_octave_shift;
        cfg.fine  = r_fine_tune;
        cfg.base  = r_base_width;
        cfg.hold  = r_hold_seconds;
        cfg.depth = r_mod_depth;
        cfg.sr    = r_sample_rate;
    end

    psno_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pitch_present (i_pitch_present),
        .i_pitch_hz      (i_pitch_hz),
        .i_width_mod     (i_width_mod),
        .i_hold_mod      (i_hold_mod),
        .o_item_valid    (fr_valid),
        .o_item          (fr_item),
        .i_item_ready    (q_ready)
    );

    psno_fifo #(
        .W     ($bits(t_item)),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign q_item = t_item'(q_data);

    psno_back #(
        .PHASE_BITS(PHASE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .i_out_ready  (i_out_ready)
    );

endmodule

/* design/psno_checker.sv */
// port-level checker for the oscillator, bound to the top level
`include "pulse_saw_noise_oscillator_macros.svh"

module psno_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_sample_out
);
    logic [2:0] r_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // transactions taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    `PSNO_AST_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `PSNO_AST_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_sample_out))
    `PSNO_AST_NOW(a_no_orphan, o_out_valid, r_cnt != 3'd0)
    `PSNO_AST_NOW(a_bounded, 1'b1, r_cnt <= 3'd5)

endmodule

bind pulse_saw_noise_oscillator psno_checker u_chk (.*);
